// ----- rtl/e2h_pkg.sv -----
`timescale 1ns / 1ps
package e2h_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int AW  = 24;   // reduced angle, degrees Q16, within +-90
  localparam int RW  = 34;   // rotation datapath, components Q30, angle Q24
  localparam int VW  = 36;   // vectoring datapath
  localparam int SQW = 63;   // square root remainder

  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [RW-1:0] rot_t;
  typedef logic signed [VW-1:0] vec_t;

  typedef struct packed {
    logic neg;
    ang_t ang;
  } red_t;

  localparam rot_t GAIN_Q30 = 34'sd652032874;
  localparam vec_t DEG180_Q24 = 36'sd3019898880;
  localparam logic signed [25:0] DEG360_Q16 = 26'sd23592960;
  localparam logic signed [25:0] DEG180_Q16 = 26'sd11796480;
  localparam logic signed [25:0] DEG90_Q16  = 26'sd5898240;

  // atan(2^-i) in degrees Q24
  localparam rot_t ATAN_Q24 [0:31] = '{
    34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
    34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
    34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
    34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
    34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
    34'sd917,       34'sd458,       34'sd229,       34'sd115,
    34'sd57,        34'sd29,        34'sd14,        34'sd7,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

  // r is already within (-360, 360); bring it to +-90 with a sign flag
  function automatic red_t fold(input logic signed [25:0] r);
    logic signed [25:0] t;
    red_t o;
    t = r;
    o.neg = 1'b0;
    if (t > DEG180_Q16) t = t - DEG360_Q16;
    if (t < -DEG180_Q16) t = t + DEG360_Q16;
    if (t > DEG90_Q16) begin
      t = t - DEG180_Q16;
      o.neg = 1'b1;
    end else if (t < -DEG90_Q16) begin
      t = t + DEG180_Q16;
      o.neg = 1'b1;
    end
    o.ang = t[AW-1:0];
    return o;
  endfunction

endpackage

// ----- rtl/e2h_cordic_rot.sv -----
`timescale 1ns / 1ps
module e2h_cordic_rot (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  e2h_pkg::ang_t angle_i,
  input  logic          neg_i,
  output logic          valid_o,
  output e2h_pkg::rot_t sin_o,
  output e2h_pkg::rot_t cos_o
);
  import e2h_pkg::*;

  rot_t x_q [0:CORDIC_STAGES];
  rot_t y_q [0:CORDIC_STAGES];
  rot_t z_q [0:CORDIC_STAGES];
  logic n_q [0:CORDIC_STAGES];
  logic v_q [0:CORDIC_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else v_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= GAIN_Q30;
    y_q[0] <= '0;
    z_q[0] <= rot_t'(angle_i) <<< 8;
    n_q[0] <= neg_i;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else v_q[i+1] <= v_q[i];
    end

    always_ff @(posedge clk_i) begin
      n_q[i+1] <= n_q[i];
      if (!z_q[i][RW-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN_Q24[i];
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN_Q24[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= v_q[CORDIC_STAGES];
  end

  // half-turn fold negates both outputs
  always_ff @(posedge clk_i) begin
    sin_o <= n_q[CORDIC_STAGES] ? -y_q[CORDIC_STAGES] : y_q[CORDIC_STAGES];
    cos_o <= n_q[CORDIC_STAGES] ? -x_q[CORDIC_STAGES] : x_q[CORDIC_STAGES];
  end

endmodule

// ----- rtl/e2h_cordic_vec.sv -----
`timescale 1ns / 1ps
module e2h_cordic_vec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  e2h_pkg::vec_t x_i,
  input  e2h_pkg::vec_t y_i,
  output logic          valid_o,
  output e2h_pkg::vec_t angle_o
);
  import e2h_pkg::*;

  vec_t x_q [0:CORDIC_STAGES];
  vec_t y_q [0:CORDIC_STAGES];
  vec_t z_q [0:CORDIC_STAGES];
  logic zero_q [0:CORDIC_STAGES];
  logic v_q [0:CORDIC_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else v_q[0] <= valid_i;
  end

  // left half plane: pre-rotate by a half turn
  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    if (x_i[VW-1]) begin
      x_q[0] <= -x_i;
      y_q[0] <= -y_i;
      z_q[0] <= y_i[VW-1] ? -DEG180_Q24 : DEG180_Q24;
    end else begin
      x_q[0] <= x_i;
      y_q[0] <= y_i;
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else v_q[i+1] <= v_q[i];
    end

    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (!y_q[i][VW-1]) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + vec_t'(ATAN_Q24[i]);
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - vec_t'(ATAN_Q24[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= v_q[CORDIC_STAGES];
  end

  always_ff @(posedge clk_i) begin
    angle_o <= zero_q[CORDIC_STAGES] ? '0 : z_q[CORDIC_STAGES];
  end

endmodule

// ----- rtl/equatorial_to_horizontal.sv -----
`timescale 1ns / 1ps
// The done_o strobe follows the start edge through reduction, sin/cos CORDIC,
// rotation multipliers, a one-bit-per-stage square root and the atan2 CORDIC.
// Throughput: one transaction per cycle; busy_o stays low, the receiver cannot stall.
// Reset: rst_ni clears the pipeline valid bits and the latitude register (0).
module equatorial_to_horizontal (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic signed [23:0] declination_deg_i,
  input  logic signed [25:0] hour_angle_deg_i,
  input  logic        observer_latitude_we_i,
  input  logic signed [23:0] observer_latitude_i,
  output logic        done_o,
  output logic [24:0] azimuth_deg_o,
  output logic signed [23:0] altitude_deg_o
);
  import e2h_pkg::*;

  localparam int SQN = 32;
  localparam logic [SQW-1:0] ONE_Q60 = SQW'(1) << 60;

  logic signed [23:0] lat_q;
  logic acc;

  assign busy_o = 1'b0;
  assign acc = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lat_q <= '0;
    else if (observer_latitude_we_i) lat_q <= observer_latitude_i;
  end

  // stage A: hour angle modulo 360 (truncating)
  logic va_q;
  logic signed [25:0] da_q, ha_q, la_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else va_q <= acc;
  end

  always_ff @(posedge clk_i) begin
    da_q <= 26'(declination_deg_i);
    la_q <= 26'(lat_q);
    if (hour_angle_deg_i >= DEG360_Q16) ha_q <= hour_angle_deg_i - DEG360_Q16;
    else if (hour_angle_deg_i <= -DEG360_Q16) ha_q <= hour_angle_deg_i + DEG360_Q16;
    else ha_q <= hour_angle_deg_i;
  end

  // stage B: fold into +-90
  logic vb_q;
  red_t db_q, hb_q, lb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    db_q <= fold(da_q);
    hb_q <= fold(ha_q);
    lb_q <= fold(la_q);
  end

  logic vr_d, vr_h, vr_l, vr;
  rot_t sd, cd, sh, ch, sl, cl;

  e2h_cordic_rot u_rot_dec (
    .clk_i, .rst_ni, .valid_i(vb_q), .angle_i(db_q.ang), .neg_i(db_q.neg),
    .valid_o(vr_d), .sin_o(sd), .cos_o(cd)
  );
  e2h_cordic_rot u_rot_ha (
    .clk_i, .rst_ni, .valid_i(vb_q), .angle_i(hb_q.ang), .neg_i(hb_q.neg),
    .valid_o(vr_h), .sin_o(sh), .cos_o(ch)
  );
  e2h_cordic_rot u_rot_lat (
    .clk_i, .rst_ni, .valid_i(vb_q), .angle_i(lb_q.ang), .neg_i(lb_q.neg),
    .valid_o(vr_l), .sin_o(sl), .cos_o(cl)
  );

  assign vr = vr_d & vr_h & vr_l;

  // M1: unit vector
  logic vm1_q;
  rot_t x1_q, y1_q, z1_q, sl1_q, cl1_q;
  logic signed [67:0] pxc, pyc;

  assign pxc = ch * cd;
  assign pyc = sh * cd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm1_q <= 1'b0;
    else vm1_q <= vr;
  end

  always_ff @(posedge clk_i) begin
    x1_q  <= pxc[63:30];
    y1_q  <= pyc[63:30];
    z1_q  <= sd;
    sl1_q <= sl;
    cl1_q <= cl;
  end

  // M2: rotation products
  logic vm2_q;
  logic signed [67:0] p1_q, p2_q, p3_q, p4_q;
  rot_t y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm2_q <= 1'b0;
    else vm2_q <= vm1_q;
  end

  always_ff @(posedge clk_i) begin
    p1_q <= x1_q * sl1_q;
    p2_q <= z1_q * cl1_q;
    p3_q <= x1_q * cl1_q;
    p4_q <= z1_q * sl1_q;
    y2_q <= y1_q;
  end

  // M3: sums, shift by 30, clamp z'
  logic vm3_q;
  logic signed [68:0] xs, zs;
  logic signed [38:0] zf;
  vec_t xr3_q;
  logic signed [31:0] zr3_q;
  rot_t y3_q;

  assign xs = {p1_q[67], p1_q} - {p2_q[67], p2_q};
  assign zs = {p3_q[67], p3_q} + {p4_q[67], p4_q};
  assign zf = zs[68:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm3_q <= 1'b0;
    else vm3_q <= vm2_q;
  end

  always_ff @(posedge clk_i) begin
    xr3_q <= xs[65:30];
    y3_q  <= y2_q;
    if (zf > 39'sd1073741824) zr3_q <= 32'sd1073741824;
    else if (zf < -39'sd1073741824) zr3_q <= -32'sd1073741824;
    else zr3_q <= zf[31:0];
  end

  // M4: z' squared
  logic vm4_q;
  logic signed [63:0] sq4_q;
  vec_t xr4_q;
  logic signed [31:0] zr4_q;
  rot_t y4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm4_q <= 1'b0;
    else vm4_q <= vm3_q;
  end

  always_ff @(posedge clk_i) begin
    sq4_q <= zr3_q * zr3_q;
    xr4_q <= xr3_q;
    zr4_q <= zr3_q;
    y4_q  <= y3_q;
  end

  // M5 and square root: one result bit per stage
  logic             sv_v_q [0:SQN];
  logic [SQW-1:0]   rem_q  [0:SQN];
  logic [SQW-1:0]   root_q [0:SQN];
  vec_t             xr_q   [0:SQN];
  logic signed [31:0] zr_q [0:SQN];
  rot_t             y_q    [0:SQN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_v_q[0] <= 1'b0;
    else sv_v_q[0] <= vm4_q;
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= ONE_Q60 - sq4_q[SQW-1:0];
    root_q[0] <= '0;
    xr_q[0]   <= xr4_q;
    zr_q[0]   <= zr4_q;
    y_q[0]    <= y4_q;
  end

  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQN - 1 - j));
    logic [SQW-1:0] trial;
    assign trial = root_q[j] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_v_q[j+1] <= 1'b0;
      else sv_v_q[j+1] <= sv_v_q[j];
    end

    always_ff @(posedge clk_i) begin
      xr_q[j+1] <= xr_q[j];
      zr_q[j+1] <= zr_q[j];
      y_q[j+1]  <= y_q[j];
      if (rem_q[j] >= trial) begin
        rem_q[j+1]  <= rem_q[j] - trial;
        root_q[j+1] <= (root_q[j] >> 1) + BIT;
      end else begin
        rem_q[j+1]  <= rem_q[j];
        root_q[j+1] <= root_q[j] >> 1;
      end
    end
  end

  // atan2 for azimuth and for altitude (asin via atan2(t, sqrt(1-t^2)))
  logic va_az, va_alt;
  vec_t az_z, alt_z;

  e2h_cordic_vec u_vec_az (
    .clk_i, .rst_ni, .valid_i(sv_v_q[SQN]),
    .x_i(xr_q[SQN]), .y_i(vec_t'(y_q[SQN])),
    .valid_o(va_az), .angle_o(az_z)
  );
  e2h_cordic_vec u_vec_alt (
    .clk_i, .rst_ni, .valid_i(sv_v_q[SQN]),
    .x_i({5'b00000, root_q[SQN][30:0]}), .y_i(vec_t'(zr_q[SQN])),
    .valid_o(va_alt), .angle_o(alt_z)
  );

  // Q24 -> Q16 with rounding, offset and clamp
  vec_t az_r, alt_r;
  logic signed [27:0] az_q16, alt_q16;
  logic signed [28:0] az_off;

  assign az_r    = az_z + 36'sd128;
  assign alt_r   = alt_z + 36'sd128;
  assign az_q16  = az_r[35:8];
  assign alt_q16 = alt_r[35:8];
  assign az_off  = {az_q16[27], az_q16} + 29'sd11796480;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= va_az & va_alt;
  end

  always_ff @(posedge clk_i) begin
    if (az_off < 29'sd0) azimuth_deg_o <= '0;
    else if (az_off > 29'sd23592960) azimuth_deg_o <= 25'd23592960;
    else azimuth_deg_o <= az_off[24:0];

    if (alt_q16 > 28'sd5898240) altitude_deg_o <= 24'sd5898240;
    else if (alt_q16 < -28'sd5898240) altitude_deg_o <= -24'sd5898240;
    else altitude_deg_o <= alt_q16[23:0];
  end

  // both atan2 units run in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni) va_az == va_alt)
    else $error("atan2 units out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> (azimuth_deg_o <= 25'd23592960))
    else $error("azimuth above 360 degrees");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> (altitude_deg_o <= 24'sd5898240 && altitude_deg_o >= -24'sd5898240))
    else $error("altitude beyond 90 degrees");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      sv_v_q[SQN] |-> (root_q[SQN] <= SQW'(1) << 30))
    else $error("square root above one");

endmodule
